// ----- rtl/l2n_pkg.sv -----
package l2n_pkg;
   localparam int RowMax = 64;
   localparam int AddrW = $clog2(RowMax);
   localparam int LenW = 7;
   localparam int AccW = 23;
   localparam logic signed [31:0] ThreeHalves = 32'sd402653184;
   localparam logic signed [31:0] Rsqrt2 = 32'sd1518500250;
   localparam logic signed [31:0] QOne = 32'sd268435456;
   localparam logic [31:0] NormLimit = 32'd536870912;
   localparam logic [1:0] CsrRowLength = 2'd0;
   localparam logic [1:0] CsrZeroPoint = 2'd1;

   function automatic logic signed [31:0] dbl_high_mul(logic signed [31:0] a,
                                                       logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] q;
      begin
         p = 64'(a) * 64'(b);
         q = p + (p >= 0 ? 64'sd1073741824 : -64'sd1073741823);
         if (a == 32'sh80000000 && b == 32'sh80000000) begin
            dbl_high_mul = 32'sh7fffffff;
         end else begin
            dbl_high_mul = 32'(q / 64'sd2147483648);
         end
      end
   endfunction

   function automatic logic signed [31:0] rshift_rnd(logic signed [31:0] x,
                                                     logic [5:0] e);
      logic [31:0] mask;
      logic [31:0] rem;
      logic [31:0] thr;
      logic signed [31:0] fl;
      logic [4:0] sh;
      begin
         sh = (e > 6'd31) ? 5'd31 : e[4:0];
         mask = (32'd1 << sh) - 32'd1;
         rem = x & mask;
         fl = x >>> sh;
         thr = (mask >> 1) + {31'd0, x[31]};
         rshift_rnd = fl + ((rem > thr) ? 32'sd1 : 32'sd0);
      end
   endfunction

   function automatic logic signed [31:0] sat_shl(logic signed [31:0] x, logic [2:0] e);
      logic signed [32:0] thr;
      begin
         thr = (33'sd1 <<< (31 - e)) - 33'sd1;
         if (33'(x) > thr) sat_shl = 32'sh7fffffff;
         else if (33'(x) < -thr) sat_shl = 32'sh80000000;
         else sat_shl = x <<< e;
      end
   endfunction
endpackage

// ----- rtl/l2n_ram.sv -----
module l2n_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/l2_normalize_int8_row_top.sv -----
// row-wise l2 normalization of int8 samples
// request channel: req_valid/req_stall with req_sample, one sample per request.
// samples are stored in a 64-entry row ram and squared into an accumulator.
// a request is taken whenever req_valid is high while a row fills.
// when the row reaches row_length (0 acts as 1, above 64 acts as 64) the block
// stops taking requests and computes the inverse square root: a normalize step
// of one bit pair per cycle (up to 13) plus a setup step, then five newton
// steps that each square t, cube it and update it, then two scale steps.
// it then reads the row ram back and sends each result on rsp_valid/rsp_stall
// with rsp_value and rsp_last (set on the row's end).
// a one-entry output register holds a stalled result; a ram read is issued only
// when no read is in flight and that register is free or being taken, so a new
// read waits until the last one has landed and a stall just holds the stream.
// csr_wr_en/csr_index/csr_data write row_length (0) and zero_point (1);
// write them only when idle.
// reset (synchronous, active high) empties the row and sets row_length 64,
// zero_point 0. the row ram is not cleared; only written entries are read.
module l2_normalize_int8_row_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [7:0]             req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [7:0]             rsp_value,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_data
);
   import l2n_pkg::*;

   typedef enum logic [2:0] {
      ST_FILL, ST_NORM, ST_NEWT, ST_SCALE, ST_OUT
   } state_type;

   state_type state_ff;
   logic [LenW-1:0] row_length_ff;
   logic signed [7:0] zero_point_ff;
   logic [AccW-1:0] acc_ff;
   logic [LenW-1:0] fill_ff;
   logic [31:0] v_ff;
   logic signed [5:0] e_ff;
   logic signed [31:0] half_ff, t_ff, m1_ff, m2_ff, mult_ff;
   logic [5:0] shift_ff;
   logic [2:0] iter_ff;
   logic [1:0] phase_ff;
   logic [LenW-1:0] rd_ptr_ff;
   logic rd_pend_ff;
   logic rd_last_ff;
   logic out_valid_ff;
   logic signed [7:0] out_value_ff;
   logic out_last_ff;

   logic [LenW-1:0] eff_len;
   logic accept, ram_we, issue, out_free;
   logic [AddrW-1:0] rd_addr;
   logic [7:0] rd_data;
   logic signed [8:0] cent_in;
   logic signed [17:0] sq;
   logic signed [31:0] x_sh, y_mul, y_fin, e_neg_t;
   logic signed [6:0] s_amt;

   assign eff_len = (row_length_ff == '0) ? LenW'(1) :
                    (row_length_ff > LenW'(RowMax)) ? LenW'(RowMax) : row_length_ff;
   assign req_stall = (state_ff != ST_FILL);
   assign accept = req_valid && !req_stall;
   assign ram_we = accept;
   assign cent_in = 9'(req_sample) - 9'(zero_point_ff);
   assign sq = 18'(cent_in) * 18'(cent_in);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign issue = (state_ff == ST_OUT) && (rd_ptr_ff < fill_ff) && !rd_pend_ff && out_free;
   assign rd_addr = rd_ptr_ff[AddrW-1:0];

   l2n_ram #(.Width(8), .Depth(RowMax)) u_row_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(fill_ff[AddrW-1:0]),
      .wr_data(req_sample),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      s_amt = 7'sd7 - 7'($signed({1'b0, shift_ff}));
      x_sh = 32'($signed(9'($signed(rd_data)) - 9'(zero_point_ff)));
      if (s_amt > 0) begin
         x_sh = x_sh <<< s_amt[5:0];
      end
      y_mul = dbl_high_mul(x_sh, mult_ff);
      y_fin = (s_amt < 0) ? rshift_rnd(y_mul, 6'(-s_amt)) : y_mul;
      e_neg_t = t_ff <<< 6'(-e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         row_length_ff <= LenW'(RowMax);
         zero_point_ff <= '0;
         acc_ff <= '0;
         fill_ff <= '0;
         rd_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         rd_ptr_ff <= '0;
         shift_ff <= '0;
         mult_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CsrRowLength: row_length_ff <= csr_data[LenW-1:0];
               CsrZeroPoint: zero_point_ff <= csr_data;
               default: ;
            endcase
         end
         if (rd_pend_ff) begin
            out_valid_ff <= 1'b1;
            out_value_ff <= (y_fin > 127) ? 8'sd127 :
                            (y_fin < -128) ? -8'sd128 : y_fin[7:0];
            out_last_ff <= rd_last_ff;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         rd_pend_ff <= issue;
         rd_last_ff <= (rd_ptr_ff + LenW'(1) == fill_ff);
         unique case (state_ff)
            ST_FILL: begin
               if (accept) begin
                  fill_ff <= fill_ff + LenW'(1);
                  acc_ff <= acc_ff + AccW'(sq);
                  if (fill_ff + LenW'(1) >= eff_len) begin
                     v_ff <= 32'(acc_ff + AccW'(sq));
                     e_ff <= 6'sd11;
                     state_ff <= ST_NORM;
                  end
               end
            end
            ST_NORM: begin
               if (v_ff <= 32'd1) begin
                  mult_ff <= 32'sh7fffffff;
                  shift_ff <= '0;
                  rd_ptr_ff <= '0;
                  state_ff <= ST_OUT;
               end else if (v_ff >= NormLimit) begin
                  v_ff <= v_ff >> 2;
                  e_ff <= e_ff + 6'sd1;
               end else if (v_ff < (NormLimit >> 2)) begin
                  v_ff <= v_ff << 2;
                  e_ff <= e_ff - 6'sd1;
               end else begin
                  half_ff <= rshift_rnd(32'(v_ff >> 1), 6'd1);
                  t_ff <= QOne;
                  iter_ff <= '0;
                  phase_ff <= '0;
                  state_ff <= ST_NEWT;
               end
            end
            ST_NEWT: begin
               phase_ff <= phase_ff + 2'd1;
               unique case (phase_ff)
                  2'd0: m1_ff <= dbl_high_mul(t_ff, t_ff);
                  2'd1: m1_ff <= sat_shl(dbl_high_mul(t_ff, m1_ff), 3'd6);
                  2'd2: begin
                     m2_ff <= dbl_high_mul(ThreeHalves, t_ff);
                     m1_ff <= dbl_high_mul(half_ff, m1_ff);
                  end
                  default: begin
                     t_ff <= sat_shl(m2_ff - m1_ff, 3'd3);
                     iter_ff <= iter_ff + 3'd1;
                     if (iter_ff == 3'd4) state_ff <= ST_SCALE;
                  end
               endcase
            end
            ST_SCALE: begin
               if (phase_ff == 2'd0) begin
                  t_ff <= dbl_high_mul(t_ff, Rsqrt2);
                  phase_ff <= 2'd1;
               end else begin
                  if (e_ff < 0) begin
                     mult_ff <= e_neg_t;
                     shift_ff <= '0;
                  end else begin
                     mult_ff <= t_ff;
                     shift_ff <= 6'(e_ff);
                  end
                  rd_ptr_ff <= '0;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (issue) rd_ptr_ff <= rd_ptr_ff + LenW'(1);
               if (rd_ptr_ff == fill_ff && !rd_pend_ff && out_free
                   && !(out_valid_ff && out_last_ff)) begin
                  fill_ff <= '0;
                  acc_ff <= '0;
                  state_ff <= ST_FILL;
               end
            end
            default: state_ff <= ST_FILL;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_last = out_last_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_FILL |-> !accept) else $error("request taken while busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LenW'(RowMax)) else $error("row overfilled");
   a_issue_free: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (!out_valid_ff || !rsp_stall)) else $error("output overrun");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff) else $error("result dropped");
`endif
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import l2n_pkg::*;

   localparam logic [1:0] CsrSpareA = 2'd2;
   localparam logic [1:0] CsrSpareB = 2'd3;
   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 80;
   localparam int HoldCycles = 700;

   typedef struct packed {
      logic signed [7:0] value;
      logic last;
   } norm_type;

   typedef struct {
      bit is_csr;
      logic [1:0] index;
      logic [7:0] data;
      bit typed;
      logic signed [7:0] value;
   } step_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [7:0] req_sample;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [7:0] rsp_value;
   logic rsp_last;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   l2_normalize_int8_row_top dut (.*);

   // predictor state
   int row_len_reg;
   int zero_pt;
   logic signed [7:0] row_buf[RowMax];
   int sq_sum;
   int fill;
   norm_type norm_q[$];

   int err_count;
   int cycle_count = 0;
   int sent_count;
   int rsp_count;
   int row_count;
   int send_idle_pct;
   int stall_pct;
   logic hold_req;
   logic hold_req_d = 1'b0;
   int hold_cnt = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int hmul(int a, int b);
      longint p;
      longint nudge;
      if (a == int'(32'h80000000) && b == int'(32'h80000000)) return 32'h7fffffff;
      p = longint'(a) * longint'(b);
      nudge = (p >= 0) ? (longint'(1) << 30) : (longint'(1) - (longint'(1) << 30));
      return int'((p + nudge) / (longint'(1) << 31));
   endfunction

   function automatic int rnd_shr(int x, int e);
      longint mask;
      longint rem;
      longint fl;
      longint thr;
      if (e > 31) e = 31;
      mask = (longint'(1) << e) - 1;
      rem = longint'(x) & mask;
      fl = (longint'(x) - rem) / (longint'(1) << e);
      thr = (mask >>> 1) + ((x < 0) ? 1 : 0);
      return int'(fl + ((rem > thr) ? 1 : 0));
   endfunction

   function automatic int sat_shl6(int x, int e);
      longint thr;
      thr = (longint'(1) << (31 - e)) - 1;
      if (longint'(x) > thr) return 32'h7fffffff;
      if (longint'(x) < -thr) return int'(32'h80000000);
      return int'(longint'(x) << e);
   endfunction

   function automatic int lead_zero_count(logic [31:0] v);
      int n;
      n = 0;
      while (n < 32 && v[31 - n] == 1'b0) n++;
      return n;
   endfunction

   function automatic void inv_root(input int sum, output int mult, output int shift);
      longint v;
      int e;
      int pairs;
      int half;
      int t;
      int t3;
      v = longint'(unsigned'(sum));
      e = 11;
      if (v <= 1) begin
         mult = 32'h7fffffff;
         shift = 0;
         return;
      end
      while (v >= (longint'(1) << 29)) begin
         v = v / 4;
         e++;
      end
      pairs = (lead_zero_count(v[31:0]) - 1) / 2 - 1;
      e -= pairs;
      v = v << (2 * pairs);
      half = rnd_shr(int'(v / 2), 1);
      t = 1 << 28;
      for (int i = 0; i < 5; i++) begin
         t3 = sat_shl6(hmul(t, hmul(t, t)), 6);
         t = sat_shl6(int'(longint'(hmul(ThreeHalves, t)) - longint'(hmul(half, t3))), 3);
      end
      t = hmul(t, Rsqrt2);
      if (e < 0) begin
         t = int'(longint'(t) << (-e));
         e = 0;
      end
      mult = t;
      shift = e;
   endfunction

   function automatic void predict_norm(logic signed [7:0] s, bit typed,
                                        logic signed [7:0] typed_value);
      int c;
      int lim;
      int mult;
      int shift;
      int sh;
      int x;
      int y;
      norm_type r;
      c = int'(s) - zero_pt;
      if (fill >= RowMax) fill = 0;
      row_buf[fill] = s;
      sq_sum += c * c;
      fill++;
      lim = (row_len_reg == 0) ? 1 : (row_len_reg > RowMax) ? RowMax : row_len_reg;
      if (fill < lim) return;
      inv_root(sq_sum, mult, shift);
      for (int k = 0; k < fill; k++) begin
         sh = 7 - shift;
         x = int'(row_buf[k]) - zero_pt;
         if (sh > 0) x = x * (1 << sh);
         y = hmul(x, mult);
         if (sh < 0) y = rnd_shr(y, -sh);
         if (y > 127) y = 127;
         if (y < -128) y = -128;
         r.value = typed ? typed_value : 8'(y);
         r.last = (k + 1 == fill);
         norm_q.push_back(r);
      end
      row_count++;
      fill = 0;
      sq_sum = 0;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (err_count < 30) begin
         $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                  want);
      end
      err_count++;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CsrRowLength) row_len_reg = int'(data[6:0]);
      else if (idx == CsrZeroPoint) zero_pt = int'(signed'(data));
      @(posedge clock);
   endtask

   task automatic send_sample(logic signed [7:0] s, bit typed, logic signed [7:0] tv);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      predict_norm(s, typed, tv);
      sent_count++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (norm_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic signed [7:0] pick_sample();
      int d;
      case ($urandom_range(0, 9))
         6, 7: begin
            d = zero_pt + int'($urandom_range(0, 6)) - 3;
            if (d > 127) d = 127;
            if (d < -128) d = -128;
            return 8'(d);
         end
         8: return $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
         9: return 8'(zero_pt);
         default: return 8'($urandom);
      endcase
   endfunction

   // response check and receiver stall
   always @(posedge clock) begin
      norm_type want;
      hold_req_d <= hold_req;
      if (rsp_valid && !rsp_stall && !reset) begin
         rsp_count++;
         if (norm_q.size() == 0) begin
            report_mismatch("unexpected response value", rsp_value, 0);
         end else begin
            want = norm_q.pop_front();
            if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
      if (hold_req && !hold_req_d) begin
         hold_cnt <= HoldCycles;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= int'($urandom_range(0, 99)) < stall_pct;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      step_type steps[$];
      int modes_send[4];
      int modes_stall[4];
      int phase;
      int len;
      int eff;
      int count;
      logic [7:0] zp;

      modes_send = '{0, 80, 0, 22};
      modes_stall = '{0, 0, 80, 22};
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_req = 1'b0;
      err_count = 0;
      sent_count = 0;
      rsp_count = 0;
      row_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      row_len_reg = 64;
      zero_pt = 0;
      sq_sum = 0;
      fill = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      steps = '{
         '{1, CsrRowLength, 8'd1, 0, 0},
         '{0, 0, 8'h00, 1, 8'sd0},
         '{0, 0, 8'h01, 1, 8'sd127},
         '{0, 0, 8'hff, 1, -8'sd128},
         '{0, 0, 8'h7f, 0, 0},
         '{0, 0, 8'h80, 0, 0},
         '{1, CsrZeroPoint, 8'h7f, 0, 0},
         '{0, 0, 8'h80, 0, 0},
         '{0, 0, 8'h7f, 1, 8'sd0},
         '{1, CsrZeroPoint, 8'h80, 0, 0},
         '{0, 0, 8'h7f, 0, 0},
         '{0, 0, 8'h80, 1, 8'sd0},
         '{1, CsrSpareA, 8'h05, 0, 0},
         '{1, CsrSpareB, 8'h55, 0, 0},
         '{1, CsrRowLength, 8'd0, 0, 0},
         '{0, 0, 8'h05, 0, 0},
         '{1, CsrZeroPoint, 8'h00, 0, 0},
         '{1, CsrRowLength, 8'd3, 0, 0},
         '{0, 0, 8'h7f, 0, 0},
         '{0, 0, 8'h80, 0, 0},
         '{0, 0, 8'h01, 0, 0},
         '{0, 0, 8'h02, 0, 0},
         '{1, CsrRowLength, 8'd2, 0, 0},
         '{0, 0, 8'hc0, 0, 0}
      };
      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            settle();
            write_csr(steps[i].index, steps[i].data);
         end else begin
            send_sample(signed'(steps[i].data), steps[i].typed, steps[i].value);
         end
      end

      phase = 0;
      while (sent_count < 430) begin
         settle();
         case ($urandom_range(0, 9))
            0: len = 1;
            1: len = 64;
            2: len = 0;
            3: len = 127;
            4: len = $urandom_range(65, 126);
            default: len = $urandom_range(1, 16);
         endcase
         case ($urandom_range(0, 4))
            0: zp = 8'h80;
            1: zp = 8'h7f;
            2: zp = 8'h00;
            default: zp = 8'($urandom);
         endcase
         if (phase == 3) len = 64;
         write_csr(CsrRowLength, 8'(len));
         write_csr(CsrZeroPoint, zp);
         send_idle_pct = modes_send[phase % 4];
         stall_pct = modes_stall[phase % 4];
         eff = (len == 0) ? 1 : (len > RowMax) ? RowMax : len;
         count = eff * int'($urandom_range(1, 3));
         if ($urandom_range(0, 3) == 0) count += $urandom_range(0, eff);
         if (eff == RowMax) count = eff;
         if (phase == 3) begin
            // long receiver hold while two full rows are offered
            send_idle_pct = 0;
            hold_req <= 1'b1;
            count = 2 * RowMax;
         end
         for (int i = 0; i < count; i++) begin
            send_sample(pick_sample(), 0, 0);
            if (phase == 3) hold_req <= 1'b0;
         end
         phase++;
      end

      settle();
      $display("%0d samples sent over %0d phases, %0d rows normalized, %0d results checked",
               sent_count, phase, row_count, rsp_count);
      $display("row lengths 0..127, zero points at both extremes, idle and stall mixes");
      if (err_count == 0 && norm_q.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches, %0d results outstanding", err_count, norm_q.size());
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/l2n_pkg.sv
rtl/l2n_ram.sv
rtl/l2_normalize_int8_row_top.sv
dv/testbench.sv
